// ===== rtl/core/jsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared beat types, status codes and UTF-8 encode helpers.
// ----------------------------------------------------------------------------
package jsu_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_byte;
        logic       no_more_data;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] status;
        logic       last_of_run;
    } result_t;

    // One decoded step: optional flushed high surrogate, optional byte or
    // code point, optional status.
    typedef struct packed {
        logic        hi_valid;
        logic [9:0]  hi_low;
        logic        cp_valid;
        logic        cp_raw;
        logic [20:0] cp;
        logic        st_valid;
        logic [2:0]  st;
    } desc_t;

    localparam logic [2:0] ST_RUNNING = 3'd0;
    localparam logic [2:0] ST_CLOSED  = 3'd1;
    localparam logic [2:0] ST_CTRL    = 3'd2;
    localparam logic [2:0] ST_BAD_U   = 3'd3;
    localparam logic [2:0] ST_BAD_ESC = 3'd4;
    localparam logic [2:0] ST_UNTERM  = 3'd5;

    localparam logic [5:0] HI_SURR_TAG = 6'b110110;
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] n;
        if (cp < 21'h80) begin
            n = 3'd1;
        end
        else if (cp < 21'h800) begin
            n = 3'd2;
        end
        else if (cp < 21'h10000) begin
            n = 3'd3;
        end
        else begin
            n = 3'd4;
        end
        return n;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                             input logic [1:0] j);
        logic [7:0] b;
        b = 8'h00;
        case (len)
            3'd2: b = (j == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3: begin
                case (j)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            3'd4: begin
                case (j)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: b = cp[7:0];
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/jsu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape front end
// Tracks escape and surrogate state; turns each accepted input beat into at
// most one step descriptor.
// ----------------------------------------------------------------------------
module jsu_front
    import jsu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  accept,
    input  wire item_t item,
    output logic       desc_push,
    output desc_t      desc
);

    localparam logic [2:0] PH_PLAIN = 3'd0;
    localparam logic [2:0] PH_ESC   = 3'd1;
    localparam logic [2:0] PH_HEX   = 3'd2;
    localparam logic [2:0] PH_HI    = 3'd3;
    localparam logic [2:0] PH_HI_BS = 3'd4;
    localparam logic [2:0] PH_LOW   = 3'd5;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] hex_reg, hex_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [9:0]  pend_reg, pend_next;
    logic        fin_reg, fin_next;

    logic [2:0]  ph;
    logic [15:0] hex;
    logic [1:0]  cnt;
    logic [9:0]  pend;
    logic        fin;
    logic [7:0]  c;
    logic [4:0]  hd;
    logic [15:0] acc;
    logic        do_plain;
    logic        do_esc;
    logic        do_finish;
    desc_t       d;

    always_comb
    begin
        ph   = item.first_byte ? PH_PLAIN : phase_reg;
        hex  = item.first_byte ? 16'd0 : hex_reg;
        cnt  = item.first_byte ? 2'd0 : cnt_reg;
        pend = item.first_byte ? 10'd0 : pend_reg;
        fin  = item.first_byte ? 1'b0 : fin_reg;
        c    = item.in_byte;
        hd   = hex_digit(c);
        acc  = {hex[11:0], hd[3:0]};

        phase_next = ph;
        hex_next   = hex;
        cnt_next   = cnt;
        pend_next  = pend;
        fin_next   = fin;
        do_plain   = 1'b0;
        do_esc     = 1'b0;
        do_finish  = 1'b0;
        d          = '0;
        d.hi_low   = pend;

        if (!fin) begin
            if (item.no_more_data) begin
                fin_next   = 1'b1;
                phase_next = PH_PLAIN;
                d.st_valid = 1'b1;
                d.st       = (ph == PH_HEX || ph == PH_LOW) ? ST_BAD_U : ST_UNTERM;
            end
            else begin
                unique case (ph)
                    PH_ESC: do_esc = 1'b1;
                    PH_HEX, PH_LOW: begin
                        if (!hd[4]) begin
                            fin_next   = 1'b1;
                            phase_next = PH_PLAIN;
                            d.st_valid = 1'b1;
                            d.st       = ST_BAD_U;
                        end
                        else begin
                            hex_next = acc;
                            cnt_next = cnt + 2'd1;
                            if (cnt == 2'd3) begin
                                if (ph == PH_HEX) begin
                                    do_finish = 1'b1;
                                end
                                else if (acc[15:10] == LO_SURR_TAG) begin
                                    phase_next = PH_PLAIN;
                                    d.cp_valid = 1'b1;
                                    d.cp       = 21'h10000 + {1'b0, pend, acc[9:0]};
                                end
                                else begin
                                    d.hi_valid = 1'b1;
                                    do_finish  = 1'b1;
                                end
                            end
                        end
                    end
                    PH_HI: begin
                        if (c == CH_BSLASH) begin
                            phase_next = PH_HI_BS;
                        end
                        else begin
                            d.hi_valid = 1'b1;
                            do_plain   = 1'b1;
                        end
                    end
                    PH_HI_BS: begin
                        if (c == CH_U) begin
                            phase_next = PH_LOW;
                            hex_next   = 16'd0;
                            cnt_next   = 2'd0;
                        end
                        else begin
                            d.hi_valid = 1'b1;
                            do_esc     = 1'b1;
                        end
                    end
                    default: do_plain = 1'b1;
                endcase

                if (do_plain) begin
                    phase_next = PH_PLAIN;
                    if (c == CH_QUOTE) begin
                        fin_next   = 1'b1;
                        d.st_valid = 1'b1;
                        d.st       = ST_CLOSED;
                    end
                    else if (c < 8'h20) begin
                        fin_next   = 1'b1;
                        d.st_valid = 1'b1;
                        d.st       = ST_CTRL;
                    end
                    else if (c == CH_BSLASH) begin
                        phase_next = PH_ESC;
                    end
                    else begin
                        d.cp_valid = 1'b1;
                        d.cp_raw   = 1'b1;
                        d.cp       = {13'd0, c};
                    end
                end

                if (do_esc) begin
                    phase_next = PH_PLAIN;
                    d.cp_raw   = 1'b1;
                    d.cp_valid = 1'b1;
                    unique case (c)
                        CH_QUOTE:  d.cp = 21'h22;
                        CH_BSLASH: d.cp = 21'h5C;
                        CH_SLASH:  d.cp = 21'h2F;
                        CH_B:      d.cp = 21'h08;
                        CH_F:      d.cp = 21'h0C;
                        CH_N:      d.cp = 21'h0A;
                        CH_R:      d.cp = 21'h0D;
                        CH_T:      d.cp = 21'h09;
                        CH_U: begin
                            d.cp_valid = 1'b0;
                            phase_next = PH_HEX;
                            hex_next   = 16'd0;
                            cnt_next   = 2'd0;
                        end
                        default: begin
                            d.cp_valid = 1'b0;
                            fin_next   = 1'b1;
                            d.st_valid = 1'b1;
                            d.st       = ST_BAD_ESC;
                        end
                    endcase
                end

                if (do_finish) begin
                    if (acc[15:10] == HI_SURR_TAG) begin
                        pend_next  = acc[9:0];
                        phase_next = PH_HI;
                    end
                    else begin
                        phase_next = PH_PLAIN;
                        d.cp_valid = 1'b1;
                        d.cp       = {5'd0, acc};
                    end
                end
            end
        end

        desc      = d;
        desc_push = accept && (d.hi_valid || d.cp_valid || d.st_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_PLAIN;
            hex_reg   <= 16'd0;
            cnt_reg   <= 2'd0;
            pend_reg  <= 10'd0;
            fin_reg   <= 1'b0;
        end
        else if (accept) begin
            phase_reg <= phase_next;
            hex_reg   <= hex_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            fin_reg   <= fin_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/jsu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape step queue
// Short FIFO of step descriptors between front and back end.
// ----------------------------------------------------------------------------
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr,
    input  wire desc_t wdata,
    output logic       full,
    input  wire logic  rd,
    output desc_t      rdata,
    output logic       empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    desc_t          entry_reg [DEPTH];
    logic [AW-1:0]  wptr_reg, wptr_next;
    logic [AW-1:0]  rptr_reg, rptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_wr;
    logic           do_rd;

    always_comb
    begin
        full       = (count_reg == CW'(DEPTH));
        empty      = (count_reg == '0);
        rdata      = entry_reg[rptr_reg];
        do_wr      = wr && !full;
        do_rd      = rd && !empty;
        wptr_next  = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
        rptr_next  = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
        count_next = count_reg + CW'(do_wr) - CW'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            entry_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else begin
            if (do_wr) begin
                wptr_reg <= wptr_next;
            end
            if (do_rd) begin
                rptr_reg <= rptr_next;
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/jsu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape back end
// Expands each step descriptor into UTF-8 byte and status result beats, one
// per cycle while the result side keeps up, through an output register.
// ----------------------------------------------------------------------------
module jsu_back
    import jsu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire desc_t head,
    input  wire logic  head_valid,
    output logic       head_pop,
    input  wire logic  pop,
    output logic       empty,
    output result_t    result
);

    logic [2:0]  pos_reg, pos_next;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     beat;
    logic        take;
    logic [2:0]  hi_n;
    logic [2:0]  cp_n;
    logic [2:0]  total;
    logic [2:0]  j;
    logic [20:0] hi_cp;

    always_comb
    begin
        hi_cp = {5'd0, HI_SURR_TAG, head.hi_low};
        hi_n  = head.hi_valid ? 3'd3 : 3'd0;
        cp_n  = !head.cp_valid ? 3'd0 : (head.cp_raw ? 3'd1 : utf8_len(head.cp));
        total = hi_n + cp_n + {2'd0, head.st_valid};
        j     = pos_reg - hi_n;
        beat  = '0;
        if (head.hi_valid && pos_reg < 3'd3) begin
            beat.out_byte   = utf8_byte(hi_cp, 3'd3, pos_reg[1:0]);
            beat.byte_valid = 1'b1;
        end
        else if (head.cp_valid && j < cp_n) begin
            beat.out_byte   = utf8_byte(head.cp, cp_n, j[1:0]);
            beat.byte_valid = 1'b1;
        end
        else begin
            beat.status = head.st;
        end
        beat.last_of_run = (pos_reg == total - 3'd1);

        take     = head_valid && (!out_valid_reg || pop);
        head_pop = take && beat.last_of_run;
        pos_next = beat.last_of_run ? 3'd0 : pos_reg + 3'd1;
        empty    = !out_valid_reg;
        result   = out_reg;
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            out_reg <= beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (take) begin
                pos_reg <= pos_next;
            end
            if (take) begin
                out_valid_reg <= 1'b1;
            end
            else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/json_string_unescape_utf8.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8
// Usage:
//   Input channel (push/full): one raw string-body beat per cycle while full is
//   low; first_byte restarts decoding, no_more_data reports end of text.
//   Result channel (empty/pop): decoded UTF-8 bytes and status beats; the
//   oldest is on result while empty is low, last_of_run marks the final
//   result of each input beat. Input beats that only consume a byte make
//   no result.
//   Path: a beat is decoded by the front end, written into the step queue
//   and then expanded by the back end into the output register.
//   Throughput: one input beat per cycle while each makes at most one
//   result and the result side keeps up; the back end emits one result per
//   cycle when not stalled, so a beat that makes more results (up to 6) holds
//   the back end longer, and full rises once the QUEUE_DEPTH step queue fills.
//   A stalled result side holds the output beat and backs up through the
//   queue to full. Reset clears decoder state, queue and the output valid flag.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire item_t item,
    output logic       empty,
    input  wire logic  pop,
    output result_t    result
);

    logic  accept;
    logic  desc_push;
    desc_t desc;
    desc_t head;
    logic  q_empty;
    logic  head_pop;

    assign accept = push && !full;

    jsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .desc_push (desc_push),
        .desc      (desc)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (desc_push),
        .wdata (desc),
        .full  (full),
        .rd    (head_pop),
        .rdata (head),
        .empty (q_empty)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!q_empty),
        .head_pop   (head_pop),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule
`default_nettype wire

// ===== rtl/core/jsu_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape port checker
// Watches the result channel of the top level.
// ----------------------------------------------------------------------------
module jsu_checker
    import jsu_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    empty,
    input wire logic    pop,
    input wire result_t result
);

    // hold a stalled beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("stalled result beat changed");

    a_byte_running: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.byte_valid) |-> (result.status == ST_RUNNING))
        else $error("data beat with nonzero status");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.byte_valid) |-> (result.status != ST_RUNNING && result.last_of_run))
        else $error("status beat not final or status missing");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.byte_valid) |-> (result.out_byte == 8'h00))
        else $error("status beat carries a byte");

endmodule

bind json_string_unescape_utf8 jsu_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8 testbench
// Sends string-body beats via push/full and checks each result beat on empty/pop
// against a built-in decoder model, or for typed rows the row's expected beat.
// A short table of directed beats comes first, then random strings, mostly
// well formed with random content, some broken or cut short, under varying gaps.
// ----------------------------------------------------------------------------
module tb_top;
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        DEC_PLAIN,
        DEC_ESC,
        DEC_HEX,
        DEC_HI,
        DEC_HI_BS,
        DEC_LOW
    } dec_phase_e;

    typedef struct packed {
        item_t   beat;
        logic    typed;
        result_t want;
    } dir_row_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam int         RUN_ITEMS = 250;

    logic    clk      = 1'b0;
    logic    rst_n    = 1'b0;
    logic    push     = 1'b0;
    logic    pop      = 1'b0;
    item_t   in_beat  = '0;
    logic    full;
    logic    empty;
    result_t out_beat;

    int push_idle_pct = 26;
    int pop_idle_pct  = 63;
    int mismatch_cnt  = 0;
    int live_cnt      = 0;

    result_t  utf8_exp_q [$];
    result_t  step_q [$];
    item_t    stim_q [$];
    dir_row_t dir_q [$];
    result_t  head;
    logic     fresh;

    dec_phase_e  dec_phase;
    logic [15:0] hex_acc;
    logic [2:0]  hex_cnt;
    logic [15:0] hi_surr;
    logic        hi_held;
    logic        str_done;

    json_string_unescape_utf8 i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (in_beat),
        .empty (empty),
        .pop   (pop),
        .result(out_beat)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------
    function automatic void decoder_clear();
        dec_phase = DEC_PLAIN;
        hex_acc   = 16'h0000;
        hex_cnt   = 3'd0;
        hi_surr   = 16'h0000;
        hi_held   = 1'b0;
        str_done  = 1'b0;
    endfunction

    function automatic void emit(logic [7:0] b, logic v, logic [2:0] s);
        result_t r;
        r = {b, v, s, 1'b0};
        if (step_q.size() < 6)
        begin
            step_q.push_back(r);
        end
    endfunction

    function automatic void emit_cp(logic [20:0] cp);
        if (cp < 21'h80)
        begin
            emit(cp[7:0], 1'b1, ST_RUNNING);
        end
        else if (cp < 21'h800)
        begin
            emit(8'hC0 | 8'(cp >> 6), 1'b1, ST_RUNNING);
            emit(8'h80 | 8'(cp & 21'h3F), 1'b1, ST_RUNNING);
        end
        else if (cp < 21'h10000)
        begin
            emit(8'hE0 | 8'(cp >> 12), 1'b1, ST_RUNNING);
            emit(8'h80 | 8'((cp >> 6) & 21'h3F), 1'b1, ST_RUNNING);
            emit(8'h80 | 8'(cp & 21'h3F), 1'b1, ST_RUNNING);
        end
        else
        begin
            emit(8'hF0 | 8'((cp >> 18) & 21'h07), 1'b1, ST_RUNNING);
            emit(8'h80 | 8'((cp >> 12) & 21'h3F), 1'b1, ST_RUNNING);
            emit(8'h80 | 8'((cp >> 6) & 21'h3F), 1'b1, ST_RUNNING);
            emit(8'h80 | 8'(cp & 21'h3F), 1'b1, ST_RUNNING);
        end
    endfunction

    function automatic void halt(logic [2:0] s);
        str_done  = 1'b1;
        dec_phase = DEC_PLAIN;
        hi_held   = 1'b0;
        emit(8'h00, 1'b0, s);
    endfunction

    function automatic logic [4:0] nibble_of(logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return {1'b1, 4'(c - 8'h30)};
        end
        if (c >= "a" && c <= "f")
        begin
            return {1'b1, 4'(c - 8'h61 + 8'd10)};
        end
        if (c >= "A" && c <= "F")
        begin
            return {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        return 5'd0;
    endfunction

    function automatic void flush_hi();
        if (hi_held)
        begin
            emit_cp({5'd0, hi_surr});
        end
        hi_held = 1'b0;
        hi_surr = 16'h0000;
    endfunction

    function automatic void plain_byte(logic [7:0] c);
        dec_phase = DEC_PLAIN;
        if (c == CH_QUOTE)
        begin
            str_done = 1'b1;
            emit(8'h00, 1'b0, ST_CLOSED);
        end
        else if (c < 8'h20)
        begin
            halt(ST_CTRL);
        end
        else if (c == CH_BSLASH)
        begin
            dec_phase = DEC_ESC;
        end
        else
        begin
            emit(c, 1'b1, ST_RUNNING);
        end
    endfunction

    function automatic void escape_byte(logic [7:0] c);
        logic [7:0] m;
        dec_phase = DEC_PLAIN;
        case (c)
            CH_QUOTE:  m = 8'h22;
            CH_BSLASH: m = 8'h5C;
            "/":       m = 8'h2F;
            "b":       m = 8'h08;
            "f":       m = 8'h0C;
            "n":       m = 8'h0A;
            "r":       m = 8'h0D;
            "t":       m = 8'h09;
            "u":
            begin
                dec_phase = DEC_HEX;
                hex_acc   = 16'h0000;
                hex_cnt   = 3'd0;
                return;
            end
            default:
            begin
                halt(ST_BAD_ESC);
                return;
            end
        endcase
        emit(m, 1'b1, ST_RUNNING);
    endfunction

    function automatic void finish_cp(logic [15:0] cp);
        if (cp >= 16'hD800 && cp <= 16'hDBFF)
        begin
            hi_surr   = cp;
            hi_held   = 1'b1;
            dec_phase = DEC_HI;
        end
        else
        begin
            emit_cp({5'd0, cp});
            dec_phase = DEC_PLAIN;
        end
    endfunction

    function automatic logic take_digit(logic [7:0] c);
        logic [4:0] d;
        d = nibble_of(c);
        if (!d[4])
        begin
            halt(ST_BAD_U);
            return 1'b0;
        end
        hex_acc = {hex_acc[11:0], d[3:0]};
        hex_cnt = hex_cnt + 3'd1;
        if (hex_cnt < 3'd4)
        begin
            return 1'b0;
        end
        hex_cnt = 3'd0;
        return 1'b1;
    endfunction

    // Fill step_q with the results of one beat; return 0 for an ignored beat.
    function automatic logic decode_beat(item_t b);
        logic [7:0]  c;
        logic [15:0] lo;
        logic [20:0] hoff;
        logic [20:0] loff;
        result_t     r;
        c = b.in_byte;
        step_q.delete();
        if (b.first_byte)
        begin
            decoder_clear();
        end
        if (str_done)
        begin
            return 1'b0;
        end
        if (b.no_more_data)
        begin
            halt((dec_phase == DEC_HEX || dec_phase == DEC_LOW) ? ST_BAD_U : ST_UNTERM);
        end
        else
        begin
            case (dec_phase)
                DEC_ESC: escape_byte(c);
                DEC_HEX:
                begin
                    if (take_digit(c))
                    begin
                        finish_cp(hex_acc);
                    end
                end
                DEC_HI:
                begin
                    if (c == CH_BSLASH)
                    begin
                        dec_phase = DEC_HI_BS;
                    end
                    else
                    begin
                        flush_hi();
                        plain_byte(c);
                    end
                end
                DEC_HI_BS:
                begin
                    if (c == "u")
                    begin
                        dec_phase = DEC_LOW;
                        hex_acc   = 16'h0000;
                        hex_cnt   = 3'd0;
                    end
                    else
                    begin
                        flush_hi();
                        escape_byte(c);
                    end
                end
                DEC_LOW:
                begin
                    if (take_digit(c))
                    begin
                        lo = hex_acc;
                        if (lo >= 16'hDC00 && lo <= 16'hDFFF)
                        begin
                            hoff    = 21'(hi_surr) - 21'hD800;
                            loff    = 21'(lo) - 21'hDC00;
                            hi_held = 1'b0;
                            hi_surr = 16'h0000;
                            emit_cp(21'h10000 + (hoff << 10) + loff);
                            dec_phase = DEC_PLAIN;
                        end
                        else
                        begin
                            flush_hi();
                            finish_cp(lo);
                        end
                    end
                end
                default: plain_byte(c);
            endcase
        end
        if (step_q.size() > 0)
        begin
            r = step_q.pop_back();
            r.last_of_run = 1'b1;
            step_q.push_back(r);
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Random string builder
    // ------------------------------------------------------------------------
    function automatic void add_byte(logic [7:0] c);
        item_t b;
        b = {c, fresh, 1'b0};
        fresh = 1'b0;
        stim_q.push_back(b);
    endfunction

    function automatic void add_eod();
        item_t b;
        b = {8'($urandom_range(0, 255)), fresh, 1'b1};
        fresh = 1'b0;
        stim_q.push_back(b);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10)
        begin
            return 8'h30 + 8'(v);
        end
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    function automatic void add_u_head(int ndig);
        add_byte(CH_BSLASH);
        add_byte("u");
        for (int k = 0; k < ndig; k++)
        begin
            add_byte(hex_char(4'($urandom_range(0, 15))));
        end
    endfunction

    function automatic void add_u(logic [15:0] cp);
        add_byte(CH_BSLASH);
        add_byte("u");
        add_byte(hex_char(cp[15:12]));
        add_byte(hex_char(cp[11:8]));
        add_byte(hex_char(cp[7:4]));
        add_byte(hex_char(cp[3:0]));
    endfunction

    function automatic logic [15:0] pick_cp(int cls);
        case (cls)
            0:       return 16'($urandom_range(16'h0000, 16'h007F));
            1:       return 16'($urandom_range(16'h0080, 16'h07FF));
            2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
            3:       return 16'($urandom_range(16'hE000, 16'hFFFF));
            4:       return 16'($urandom_range(16'hDC00, 16'hDFFF));
            default: return 16'($urandom_range(16'hD800, 16'hDBFF));
        endcase
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(8'h20, 8'hFF));
        end
        while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] esc_char(int k);
        case (k)
            0:       return CH_QUOTE;
            1:       return CH_BSLASH;
            2:       return "/";
            3:       return "b";
            4:       return "f";
            5:       return "n";
            6:       return "r";
            default: return "t";
        endcase
    endfunction

    function automatic logic [7:0] bad_esc();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (c == CH_QUOTE || c == CH_BSLASH || c == "/" || c == "b" || c == "f" ||
               c == "n" || c == "r" || c == "t" || c == "u");
        return c;
    endfunction

    function automatic logic [7:0] bad_hex();
        logic [7:0] c;
        logic [4:0] d;
        do
        begin
            c = 8'($urandom_range(0, 255));
            d = nibble_of(c);
        end
        while (d[4]);
        return c;
    endfunction

    function automatic void build_string();
        int   ntok;
        int   bad_at;
        int   pick;
        logic noisy;
        fresh  = 1'b1;
        ntok   = $urandom_range(1, 6);
        noisy  = ($urandom_range(0, 99) < 20);
        bad_at = $urandom_range(0, ntok - 1);
        for (int k = 0; k < ntok; k++)
        begin
            if (noisy && k == bad_at)
            begin
                case ($urandom_range(0, 5))
                    0: add_byte(8'($urandom_range(0, 255)));
                    1:
                    begin
                        add_byte(CH_BSLASH);
                        add_byte(bad_esc());
                    end
                    2:
                    begin
                        add_u_head($urandom_range(0, 3));
                        add_byte(bad_hex());
                    end
                    3:
                    begin
                        add_u(pick_cp(5));
                        add_u_head($urandom_range(0, 3));
                        if ($urandom_range(0, 1))
                        begin
                            add_byte(bad_hex());
                        end
                        else
                        begin
                            add_eod();
                        end
                    end
                    4:
                    begin
                        add_u_head($urandom_range(0, 3));
                        add_eod();
                    end
                    default: add_eod();
                endcase
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: add_byte(pick_plain());
                    4, 5:
                    begin
                        add_byte(CH_BSLASH);
                        add_byte(esc_char($urandom_range(0, 7)));
                    end
                    6, 7: add_u(pick_cp($urandom_range(0, 5)));
                    8:
                    begin
                        add_u(pick_cp(5));
                        add_u(pick_cp(4));
                    end
                    default: add_u(pick_cp(5));
                endcase
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            add_byte(CH_QUOTE);
        end
        else if (pick < 88)
        begin
            add_eod();
        end
        if ($urandom_range(0, 99) < 15)
        begin
            add_byte(pick_plain());
        end
    endfunction

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------
    function automatic void add_dir(logic [7:0] c, logic fb, logic eod, logic typed,
                                    logic [7:0] ob, logic bv, logic [2:0] st);
        dir_row_t row;
        row.beat  = {c, fb, eod};
        row.typed = typed;
        row.want  = {ob, bv, st, 1'b1};
        dir_q.push_back(row);
    endfunction

    function automatic void add_dir_str(string s);
        for (int k = 0; k < s.len(); k++)
        begin
            add_dir(s[k], 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_RUNNING);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender and checker
    // ------------------------------------------------------------------------
    task automatic drive_beat(item_t b, logic typed, result_t want);
        while ($urandom_range(0, 99) < push_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_beat <= b;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        if (decode_beat(b))
        begin
            live_cnt++;
        end
        if (typed)
        begin
            utf8_exp_q.push_back(want);
        end
        else
        begin
            foreach (step_q[k])
            begin
                utf8_exp_q.push_back(step_q[k]);
            end
        end
    endtask

    task automatic report_bad(string why, result_t got, result_t want);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
        begin
            $display("%0t %s: got byte %02h valid %0d status %0d last %0d, expected byte %02h valid %0d status %0d last %0d",
                     $time, why, got.out_byte, got.byte_valid, got.status, got.last_of_run,
                     want.out_byte, want.byte_valid, want.status, want.last_of_run);
        end
    endtask

    always @(posedge clk)
    begin
        pop <= rst_n && ($urandom_range(0, 99) >= pop_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (utf8_exp_q.size() == 0)
            begin
                report_bad("unexpected result beat", out_beat, '0);
            end
            else
            begin
                head = utf8_exp_q.pop_front();
                if (out_beat.out_byte !== head.out_byte ||
                    out_beat.byte_valid !== head.byte_valid ||
                    out_beat.status !== head.status ||
                    out_beat.last_of_run !== head.last_of_run)
                begin
                    report_bad("result mismatch", out_beat, head);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("** json_string_unescape_utf8: FAILED **");
        $finish;
    end

    initial
    begin
        decoder_clear();
        add_dir(8'hFF, 1'b1, 1'b0, 1'b1, 8'hFF, 1'b1, ST_RUNNING);
        add_dir_str("\\uD83D");
        add_dir_str("\\ude00");
        add_dir_str("\\uDBFF");
        add_dir(CH_QUOTE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_RUNNING);
        add_dir(8'h20, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_RUNNING);
        add_dir(8'h00, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0, ST_CTRL);
        add_dir(CH_BSLASH, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, ST_RUNNING);
        add_dir("q", 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, ST_BAD_ESC);
        add_dir(8'h00, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, ST_UNTERM);
        add_dir(CH_BSLASH, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, ST_RUNNING);
        add_dir("u", 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, ST_RUNNING);
        add_dir(8'hA5, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, ST_BAD_U);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_q[k])
        begin
            drive_beat(dir_q[k].beat, dir_q[k].typed, dir_q[k].want);
        end

        live_cnt = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    push_idle_pct = 26;
                    pop_idle_pct  = 63;
                end
                1:
                begin
                    push_idle_pct = 63;
                    pop_idle_pct  = 26;
                end
                default:
                begin
                    push_idle_pct = 0;
                    pop_idle_pct  = 0;
                end
            endcase
            while (live_cnt < (ph + 1) * RUN_ITEMS / 3)
            begin
                build_string();
                while (stim_q.size() != 0)
                begin
                    drive_beat(stim_q.pop_front(), 1'b0, '0);
                end
            end
        end
        push <= 1'b0;

        // drain, then wait for stray beats
        while (utf8_exp_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (mismatch_cnt == 0)
        begin
            $display("** json_string_unescape_utf8: PASSED **");
        end
        else
        begin
            $display("** json_string_unescape_utf8: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/jsu_pkg.sv
rtl/core/jsu_front.sv
rtl/core/jsu_queue.sv
rtl/core/jsu_back.sv
rtl/core/json_string_unescape_utf8.sv
rtl/core/jsu_checker.sv
tb/tb_top.sv
